// ----- design/u2u_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
package u2u_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned DEPTH   = 4;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  localparam logic [CP_W-1:0]   CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h010000;
  localparam logic [CP_W-1:0]   CP_ONE_MAX   = 21'h00007F;
  localparam logic [CP_W-1:0]   CP_TWO_MAX   = 21'h0007FF;
  localparam logic [CP_W-1:0]   CP_BMP_MAX   = 21'h00FFFF;
  localparam logic [UNIT_W-1:0] SURR_MASK    = 16'hF800;
  localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;

  // One UTF-16 code unit with its flags
  typedef struct packed {
    logic [UNIT_W-1:0] code;
    logic              last;
    logic              bad;
  } unit_t;

  // Units produced by one accepted byte
  typedef struct packed {
    logic [1:0] n_units;
    unit_t      u0;
    unit_t      u1;
  } result_t;

endpackage

// ----- design/u2u_decode.sv -----
// Byte decoder: sequence state and per-byte code-unit generation.
`timescale 1ns / 1ps
module u2u_decode import u2u_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  output result_t           res_o
);

  logic [CP_W-1:0] acc_q, acc_d;
  logic [1:0]      rem_q, rem_d;
  logic [2:0]      seq_q, seq_d;
  logic            disc_q, disc_d;

  logic [CP_W-1:0] acc_cat;
  logic [CP_W-1:0] supp;
  logic [2:0]      enc_len;
  logic            val_bad;

  // Gather the next six payload bits and check the finished code point
  always_comb begin
    acc_cat = {acc_q[CP_W-7:0], byte_i[5:0]};
    supp    = acc_cat - CP_SUPP_BASE;
    if (acc_cat <= CP_ONE_MAX) begin
      enc_len = 3'd1;
    end else if (acc_cat <= CP_TWO_MAX) begin
      enc_len = 3'd2;
    end else if (acc_cat <= CP_BMP_MAX) begin
      enc_len = 3'd3;
    end else begin
      enc_len = 3'd4;
    end
    val_bad = (enc_len != seq_q)
           || ((acc_cat < CP_BMP_MAX)
               && ((acc_cat[UNIT_W-1:0] & SURR_MASK) == SURR_HI_BASE))
           || (acc_cat > CP_MAX);
  end

  // Next state and results for one transaction
  always_comb begin
    logic rej;
    logic rej_end;
    rej     = 1'b0;
    rej_end = 1'b0;
    acc_d   = acc_q;
    rem_d   = rem_q;
    seq_d   = seq_q;
    disc_d  = disc_q;
    res_o   = '0;
    if (accept_i) begin
      if (disc_q) begin
        // drop bytes through the next NUL
        if (byte_i == '0) begin
          disc_d = 1'b0;
        end
      end else if (rem_q == 2'd0) begin
        case (byte_i) inside
          8'h00: begin
            res_o.n_units = 2'd1;
            res_o.u0.last = 1'b1;
          end
          8'b0???????: begin
            res_o.n_units = 2'd1;
            res_o.u0.code = {8'h00, byte_i};
          end
          8'b110?????: begin
            acc_d = {16'h0000, byte_i[4:0]};
            rem_d = 2'd1;
            seq_d = 3'd2;
          end
          8'b1110????: begin
            acc_d = {17'h00000, byte_i[3:0]};
            rem_d = 2'd2;
            seq_d = 3'd3;
          end
          8'b11110???: begin
            acc_d = {18'h00000, byte_i[2:0]};
            rem_d = 2'd3;
            seq_d = 3'd4;
          end
          default: begin
            rej = 1'b1;
          end
        endcase
      end else if (byte_i == '0) begin
        rej     = 1'b1;
        rej_end = 1'b1;
      end else if (byte_i[7:6] != 2'b10) begin
        rej = 1'b1;
      end else begin
        acc_d = acc_cat;
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          if (val_bad) begin
            rej = 1'b1;
          end else begin
            acc_d = '0;
            seq_d = '0;
            if (acc_cat <= CP_BMP_MAX) begin
              res_o.n_units = 2'd1;
              res_o.u0.code = acc_cat[UNIT_W-1:0];
            end else begin
              res_o.n_units = 2'd2;
              res_o.u0.code = SURR_HI_BASE | {6'h00, supp[19:10]};
              res_o.u1.code = SURR_LO_BASE | {6'h00, supp[9:0]};
            end
          end
        end
      end
      // Error terminator; skip the rest unless this byte ended the string
      if (rej) begin
        acc_d         = '0;
        rem_d         = '0;
        seq_d         = '0;
        disc_d        = !rej_end;
        res_o         = '0;
        res_o.n_units = 2'd1;
        res_o.u0.last = 1'b1;
        res_o.u0.bad  = 1'b1;
      end
    end
  end

  // Hold sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      seq_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      seq_q  <= seq_d;
      disc_q <= disc_d;
    end
  end

`ifndef SYNTHESIS
  a_disc_at_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (rem_q == 2'd0))
    else $error("discarding inside a sequence");
  a_len_tracks_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 2'd0) |-> (seq_q > {1'b0, rem_q}))
    else $error("sequence length below remaining count");
  a_pair_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.n_units == 2'd2) |-> (!res_o.u0.last && !res_o.u1.last))
    else $error("surrogate pair flagged as terminator");
`endif

endmodule

// ----- design/u2u_out_fifo.sv -----
// Result queue: takes up to two code units per cycle, sends one per cycle while stall_i is low.
`timescale 1ns / 1ps
module u2u_out_fifo import u2u_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  result_t res_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output unit_t   unit_o
);

  unit_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  // Leave room for a surrogate pair before taking a new byte
  assign full_o  = cnt_q > CNT_W'(DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign unit_o  = mem_q[rd_q];
  assign pop     = valid_o && !stall_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q + PTR_W'(res_i.n_units);
    rd_d  = pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + CNT_W'(res_i.n_units) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store incoming units
  always_ff @(posedge clk_i) begin
    if (res_i.n_units != 2'd0) begin
      mem_q[wr_q] <= res_i.u0;
    end
    if (res_i.n_units == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= res_i.u1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_i.n_units != 2'd0) |-> !full_o)
    else $error("push into full result queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_i.n_units == 2'd0 && pop) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("occupancy did not drop on pop");
`endif

endmodule

// ----- design/utf8_to_utf16_transcoder_unit.sv -----
// UTF-8 to UTF-16 transcoder top level.
// Output: the code units of an accepted byte are registered in the result queue before reaching code_unit_o.
// Throughput: one byte per cycle while in_stall_o is low; a surrogate pair leaves as two units,
//   so the four-entry result queue raises in_stall_o only when more than two units wait.
// Reset: rst_ni clears sequence state and empties the queue; no clearing pass.
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder_unit import u2u_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [UNIT_W-1:0] code_unit_o,
  output logic              is_last_o,
  output logic              bad_input_o
);

  logic    accept;
  logic    full;
  result_t res;
  unit_t   head;

  // Take a transaction when the queue has room for a pair
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  u2u_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .res_o    (res)
  );

  u2u_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .unit_o  (head)
  );

  assign code_unit_o = head.code;
  assign is_last_o   = head.last;
  assign bad_input_o = head.bad;

endmodule
